### rtl/fpsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_pkg
// shared types and codes of the fit-policy segment allocator
// ----------------------------------------------------------------------------
package fpsa_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = 4;
    localparam int CNT_W  = 5;
    localparam int UNIT_W = 6;

    localparam logic       REQ_ALLOC  = 1'b0;
    localparam logic       REQ_FREE   = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [1:0] POL_BEST   = 2'd0;
    localparam logic [1:0] POL_FIRST  = 2'd1;
    localparam logic [1:0] POL_WORST  = 2'd2;

    localparam logic [1:0] CLS_ICU    = 2'd0;
    localparam logic [1:0] CLS_ISO    = 2'd1;
    localparam logic [1:0] CLS_GEN    = 2'd2;

    localparam logic [2:0] ADDR_FIT_POLICY = 3'd0;

    typedef struct packed {
        logic [3:0]        id;
        logic [UNIT_W-1:0] start;
        logic [UNIT_W-1:0] size;
        logic              free;
        logic [1:0]        cls;
    } seg_t;

    typedef struct packed {
        logic       req_type;
        logic [4:0] units_needed;
        logic [1:0] bed_class;
        logic [3:0] bed_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  granted_id;
        logic [15:0] patient_id;
        logic [4:0]  free_units;
        logic [4:0]  largest_free;
    } rsp_t;

endpackage

### rtl/fpsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_ram
// generic simple dual-port ram, one write port, registered read
// ----------------------------------------------------------------------------
module fpsa_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/fpsa_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_engine
// sequencer that scans, updates and compacts the segment table in ram
// ----------------------------------------------------------------------------
module fpsa_engine #(
    parameter int ICU_BEDS = 4,
    parameter int ISO_BEDS = 4,
    parameter int GEN_BEDS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [1:0]                         fit_policy,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  fpsa_pkg::req_t                     req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output fpsa_pkg::rsp_t                     rsp,
    output logic                               wr_en,
    output logic [fpsa_pkg::ADDR_W-1:0]        wr_addr,
    output logic [$bits(fpsa_pkg::seg_t)-1:0]  wr_data,
    output logic [fpsa_pkg::ADDR_W-1:0]        rd_addr,
    input  logic [$bits(fpsa_pkg::seg_t)-1:0]  rd_data
);

    localparam int SUM_BEDS  = ICU_BEDS + ISO_BEDS + GEN_BEDS;
    localparam int INIT_CNT  = (SUM_BEDS > fpsa_pkg::DEPTH) ? fpsa_pkg::DEPTH : SUM_BEDS;
    localparam int ISO_START = 3 * ICU_BEDS;
    localparam int GEN_START = 3 * ICU_BEDS + 2 * ISO_BEDS;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SCAN, S_WRITE, S_MERGE, S_STATS, S_DONE
    } state_t;

    function automatic fpsa_pkg::seg_t layout(input logic [fpsa_pkg::ADDR_W-1:0] idx);
        fpsa_pkg::seg_t s;
        int             i;
        i       = int'(idx);
        s.id    = idx;
        s.free  = 1'b1;
        if (i < ICU_BEDS)
        begin
            s.start = fpsa_pkg::UNIT_W'(3 * i);
            s.size  = fpsa_pkg::UNIT_W'(3);
            s.cls   = fpsa_pkg::CLS_ICU;
        end
        else if (i < ICU_BEDS + ISO_BEDS)
        begin
            s.start = fpsa_pkg::UNIT_W'(ISO_START + 2 * (i - ICU_BEDS));
            s.size  = fpsa_pkg::UNIT_W'(2);
            s.cls   = fpsa_pkg::CLS_ISO;
        end
        else
        begin
            s.start = fpsa_pkg::UNIT_W'(GEN_START + (i - ICU_BEDS - ISO_BEDS));
            s.size  = fpsa_pkg::UNIT_W'(1);
            s.cls   = fpsa_pkg::CLS_GEN;
        end
        return s;
    endfunction

    state_t                        state_reg, state_next;
    logic [fpsa_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [15:0]                   patient_reg, patient_next;
    fpsa_pkg::req_t                rq_reg, rq_next;
    logic [fpsa_pkg::CNT_W-1:0]    raddr_reg, raddr_next;
    logic                          pend_reg, pend_next;
    logic [fpsa_pkg::ADDR_W-1:0]   pidx_reg, pidx_next;
    logic                          found_reg, found_next;
    logic [fpsa_pkg::ADDR_W-1:0]   pick_idx_reg, pick_idx_next;
    fpsa_pkg::seg_t                pick_reg, pick_next;
    fpsa_pkg::seg_t                acc_reg, acc_next;
    logic                          have_acc_reg, have_acc_next;
    logic [fpsa_pkg::ADDR_W-1:0]   widx_reg, widx_next;
    logic [fpsa_pkg::UNIT_W:0]     total_reg, total_next;
    logic [fpsa_pkg::UNIT_W-1:0]   largest_reg, largest_next;
    logic [1:0]                    status_reg, status_next;
    logic [3:0]                    granted_reg, granted_next;
    logic [15:0]                   pid_reg, pid_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    fpsa_pkg::rsp_t                rsp_reg, rsp_next;

    fpsa_pkg::seg_t                rd_seg;
    fpsa_pkg::seg_t                b_seg;
    logic                          issue;
    logic                          scan_end;
    logic                          fits;
    logic                          better;
    logic                          mergeable;

    assign rd_seg    = fpsa_pkg::seg_t'(rd_data);
    assign rd_addr   = raddr_reg[fpsa_pkg::ADDR_W-1:0];
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign scan_end  = (raddr_reg == cnt_reg) && !pend_reg;

    always_comb
    begin
        b_seg = rd_seg;
        if (pidx_reg == pick_idx_reg)
        begin
            b_seg.free = 1'b1;
        end
    end

    assign fits = rd_seg.free && (rd_seg.cls == rq_reg.bed_class)
                  && (rd_seg.size >= {1'b0, rq_reg.units_needed});

    always_comb
    begin
        if (!found_reg)
        begin
            better = 1'b1;
        end
        else if (fit_policy == fpsa_pkg::POL_BEST)
        begin
            better = rd_seg.size < pick_reg.size;
        end
        else if (fit_policy == fpsa_pkg::POL_FIRST)
        begin
            better = 1'b0;
        end
        else
        begin
            better = rd_seg.size > pick_reg.size;
        end
    end

    assign mergeable = acc_reg.free && b_seg.free && (acc_reg.cls == b_seg.cls)
                       && (({1'b0, acc_reg.start} + {1'b0, acc_reg.size})
                           == {1'b0, b_seg.start});

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        patient_next   = patient_reg;
        rq_next        = rq_reg;
        raddr_next     = raddr_reg;
        pend_next      = 1'b0;
        pidx_next      = raddr_reg[fpsa_pkg::ADDR_W-1:0];
        found_next     = found_reg;
        pick_idx_next  = pick_idx_reg;
        pick_next      = pick_reg;
        acc_next       = acc_reg;
        have_acc_next  = have_acc_reg;
        widx_next      = widx_reg;
        total_next     = total_reg;
        largest_next   = largest_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        pid_next       = pid_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = widx_reg;
        wr_data        = acc_reg;
        issue          = (raddr_reg < cnt_reg);

        case (state_reg)
            S_INIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = raddr_reg[fpsa_pkg::ADDR_W-1:0];
                wr_data    = layout(raddr_reg[fpsa_pkg::ADDR_W-1:0]);
                raddr_next = raddr_reg + 1'b1;
                if (raddr_reg == fpsa_pkg::CNT_W'(fpsa_pkg::DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    rq_next      = req;
                    raddr_next   = '0;
                    found_next   = 1'b0;
                    status_next  = fpsa_pkg::ST_DONE;
                    granted_next = '0;
                    pid_next     = '0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    pend_next  = 1'b1;
                    raddr_next = raddr_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (rq_reg.req_type == fpsa_pkg::REQ_ALLOC)
                    begin
                        if (fits && better)
                        begin
                            found_next    = 1'b1;
                            pick_idx_next = pidx_reg;
                            pick_next     = rd_seg;
                        end
                    end
                    else if (!found_reg && (rd_seg.id == rq_reg.bed_id))
                    begin
                        found_next    = 1'b1;
                        pick_idx_next = pidx_reg;
                    end
                end
                if (scan_end)
                begin
                    raddr_next    = '0;
                    have_acc_next = 1'b0;
                    widx_next     = '0;
                    total_next    = '0;
                    largest_next  = '0;
                    if (!found_reg)
                    begin
                        status_next = (rq_reg.req_type == fpsa_pkg::REQ_ALLOC)
                                      ? fpsa_pkg::ST_NO_FIT : fpsa_pkg::ST_UNKNOWN;
                        state_next  = S_STATS;
                    end
                    else if (rq_reg.req_type == fpsa_pkg::REQ_ALLOC)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_MERGE;
                    end
                end
            end
            S_WRITE:
            begin
                wr_en        = 1'b1;
                wr_addr      = pick_idx_reg;
                wr_data      = pick_reg;
                wr_data[$bits(fpsa_pkg::seg_t)-1-4-2*fpsa_pkg::UNIT_W] = 1'b0;
                granted_next = pick_reg.id;
                pid_next     = patient_reg;
                patient_next = patient_reg + 16'd1;
                state_next   = S_STATS;
            end
            S_MERGE:
            begin
                if (issue)
                begin
                    pend_next  = 1'b1;
                    raddr_next = raddr_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (!have_acc_reg)
                    begin
                        acc_next      = b_seg;
                        have_acc_next = 1'b1;
                    end
                    else if (mergeable)
                    begin
                        acc_next.size = acc_reg.size + b_seg.size;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        widx_next = widx_reg + 1'b1;
                        acc_next  = b_seg;
                    end
                end
                if (scan_end)
                begin
                    wr_en      = 1'b1;
                    cnt_next   = {1'b0, widx_reg} + 1'b1;
                    raddr_next = '0;
                    state_next = S_STATS;
                end
            end
            S_STATS:
            begin
                if (issue)
                begin
                    pend_next  = 1'b1;
                    raddr_next = raddr_reg + 1'b1;
                end
                if (pend_reg && rd_seg.free)
                begin
                    total_next = total_reg + {1'b0, rd_seg.size};
                    if (rd_seg.size > largest_reg)
                    begin
                        largest_next = rd_seg.size;
                    end
                end
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = status_reg;
                    rsp_next.granted_id = granted_reg;
                    rsp_next.patient_id = pid_reg;
                    rsp_next.free_units = (total_reg > 7'd31) ? 5'd31 : total_reg[4:0];
                    rsp_next.largest_free = (largest_reg > 6'd31) ? 5'd31
                                            : largest_reg[4:0];
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= fpsa_pkg::CNT_W'(INIT_CNT);
            patient_reg   <= '0;
            raddr_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            have_acc_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rq_reg        <= '0;
            pidx_reg      <= '0;
            pick_idx_reg  <= '0;
            pick_reg      <= '0;
            acc_reg       <= '0;
            widx_reg      <= '0;
            total_reg     <= '0;
            largest_reg   <= '0;
            status_reg    <= '0;
            granted_reg   <= '0;
            pid_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            patient_reg   <= patient_next;
            raddr_reg     <= raddr_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            have_acc_reg  <= have_acc_next;
            rsp_valid_reg <= rsp_valid_next;
            rq_reg        <= rq_next;
            pidx_reg      <= pidx_next;
            pick_idx_reg  <= pick_idx_next;
            pick_reg      <= pick_next;
            acc_reg       <= acc_next;
            widx_reg      <= widx_next;
            total_reg     <= total_next;
            largest_reg   <= largest_next;
            status_reg    <= status_next;
            granted_reg   <= granted_next;
            pid_reg       <= pid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // table never grows past its depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= fpsa_pkg::CNT_W'(fpsa_pkg::DEPTH))
        else $error("segment count beyond table depth");

    // compaction never grows the table
    a_merge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |=> (cnt_reg <= $past(cnt_reg)))
        else $error("merge pass grew the table");

    // largest free segment is part of the free total
    a_largest_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.largest_free <= rsp_reg.free_units))
        else $error("largest free exceeds free units");

    // failed requests carry no grant
    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != fpsa_pkg::ST_DONE))
        |-> ((rsp_reg.granted_id == 4'd0) && (rsp_reg.patient_id == 16'd0)))
        else $error("grant reported on a failed request");

endmodule

### rtl/fit_policy_segment_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_segment_allocator_top
// whole-segment allocator with best, first or worst fit and free coalescing
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | req_valid/req_stall | fpsa_pkg::req_t request
//  rsp     | out       | rsp_valid/rsp_stall | fpsa_pkg::rsp_t result
//  apb     | in/out    | psel/penable/pready | fit_policy register at 0x0
//
//  one request at a time; each is served by sequential scans of the table
//  over the single read port of the segment ram: a search scan, then the
//  write of the granted segment for an allocate or a merge scan for a free
//  (neither when nothing fits or the id is unknown), then a statistics
//  scan; the engine returns to idle before the next request is taken
//  after reset the layout is written into every ram entry, during
//  which req_stall stays high (register writes are taken throughout)
//  the result sits in an output register, so a new request is taken while
//  an earlier result is still stalled
// ----------------------------------------------------------------------------
module fit_policy_segment_allocator_top #(
    parameter int ICU_BEDS = 4,
    parameter int ISO_BEDS = 4,
    parameter int GEN_BEDS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  fpsa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output fpsa_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int SEG_W = $bits(fpsa_pkg::seg_t);

    logic [1:0]                  fit_policy_reg;
    logic                        wr_en;
    logic [fpsa_pkg::ADDR_W-1:0] wr_addr;
    logic [SEG_W-1:0]            wr_data;
    logic [fpsa_pkg::ADDR_W-1:0] rd_addr;
    logic [SEG_W-1:0]            rd_data;
    logic                        reg_sel;

    // register decode on the word address, one register only
    assign reg_sel = (paddr[2] == fpsa_pkg::ADDR_FIT_POLICY[2]);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {30'd0, fit_policy_reg} : 32'd0;

    // fit policy, written during the access phase of a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= fpsa_pkg::POL_BEST;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            fit_policy_reg <= pwdata[1:0];
        end
    end

    // segment table storage
    fpsa_ram #(
        .WIDTH (SEG_W),
        .DEPTH (fpsa_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // scan, allocate, merge and statistics sequencer
    fpsa_engine #(
        .ICU_BEDS (ICU_BEDS),
        .ISO_BEDS (ISO_BEDS),
        .GEN_BEDS (GEN_BEDS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .fit_policy (fit_policy_reg),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

endmodule
